@@ hw/rtl/srlp_pkg.sv @@
// Package with the shared types and constants of the sensor record line parser.
package srlp_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SYNTAX  = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  typedef enum logic [11:0] {
    PH_TS_WS    = 12'b000000000001,
    PH_TS_SIGN  = 12'b000000000010,
    PH_TS_DIG   = 12'b000000000100,
    PH_SEN_WS   = 12'b000000001000,
    PH_SEN_SIGN = 12'b000000010000,
    PH_SEN_DIG  = 12'b000000100000,
    PH_MET_WS   = 12'b000001000000,
    PH_MET_SIGN = 12'b000010000000,
    PH_MET_DIG  = 12'b000100000000,
    PH_MET_CR   = 12'b001000000000,
    PH_DONE     = 12'b010000000000,
    PH_ERR      = 12'b100000000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] timestamp;
    logic [7:0]  sensor;
    logic [31:0] metric;
  } result_t;

endpackage

@@ hw/rtl/sensor_record_line_parser_core.sv @@
// Top level of the sensor record line parser: parser front and result queue.
//
//  channel | handshake          | payload
//  input   | push / full        | char_byte, byte_present, line_end
//  result  | empty / pop        | status, timestamp, sensor, metric
//
// One byte per cycle while full is low; a result is registered before it is queued.
// Full rises when three results wait, leaving room for the one still in the parser.
// Reset is synchronous and clears the parse state and the queue.
// A stalled consumer only stops input once the four-entry queue is nearly full.
module sensor_record_line_parser_core #(
  parameter int MAX_LINE_LEN = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        byte_present,
  input  logic        line_end,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [63:0] timestamp,
  output logic [7:0]  sensor,
  output logic signed [31:0] metric
);

  logic res_valid, afull;
  srlp_pkg::result_t res, q;

  srlp_parse #(.MAX_LINE_LEN(MAX_LINE_LEN)) u_parse (
    .clk, .rst, .in_valid(push && !full), .char_byte, .byte_present, .line_end,
    .res_valid, .res
  );

  srlp_queue u_queue (
    .clk, .rst, .wr(res_valid), .wdata(res), .rd(pop), .empty,
    .almost_full(afull), .rdata(q)
  );

  assign full = afull;
  assign status = q.status;
  assign timestamp = q.timestamp;
  assign sensor = q.sensor;
  assign metric = q.metric;

endmodule

@@ hw/rtl/srlp_parse.sv @@
// Front part: takes bytes, runs the field parser and hands finished lines on.
module srlp_parse #(
  parameter int MAX_LINE_LEN = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          char_byte,
  input  logic                byte_present,
  input  logic                line_end,
  output logic                res_valid,
  output srlp_pkg::result_t   res
);

  localparam int CW = $clog2(MAX_LINE_LEN + 2);
  localparam logic [CW-1:0] LIM = CW'(MAX_LINE_LEN);
  localparam logic [63:0] TLIM = 64'hFFFFFFFFFFFFFFFF / 10;

  srlp_pkg::phase_t phase, phase_next, ph;
  logic [63:0] time_accum, time_next, ta;
  logic [8:0]  sensor_accum, sensor_next, sa;
  logic [32:0] metric_magnitude, metric_next, ma;
  logic [2:0]  neg, neg_next, ng;
  logic        pending_crlf, pend_next;
  logic [1:0]  first_error, ferr_next, fe;
  logic [CW-1:0] byte_count, cnt_next;
  logic [1:0]  status;

  always_comb begin
    logic [7:0] c;
    logic dig, ws, sgn, runb;
    logic [3:0] d;
    logic [63:0] t10;
    logic [11:0] s10;
    logic [36:0] m10;
    logic [32:0] mlim;
    ph = phase; ta = time_accum; sa = sensor_accum; ma = metric_magnitude;
    ng = neg; fe = first_error;
    pend_next = pending_crlf;
    cnt_next = byte_count;
    c = char_byte;
    runb = 1'b0;
    if (in_valid && byte_present) begin
      if (byte_count <= LIM) cnt_next = byte_count + CW'(1);
      if (phase == srlp_pkg::PH_DONE || phase == srlp_pkg::PH_ERR) begin
      end else if (char_byte == 8'h0d || char_byte == 8'h0a) begin
        if (phase == srlp_pkg::PH_MET_DIG) runb = 1'b1;
        else if (phase != srlp_pkg::PH_MET_CR) pend_next = 1'b1;
      end else if (phase == srlp_pkg::PH_MET_CR) begin
        ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE;
      end else if (pending_crlf) begin
        // Held CR/LF: inner white space, end after metric digits, else error.
        pend_next = 1'b0;
        if (phase == srlp_pkg::PH_TS_WS || phase == srlp_pkg::PH_SEN_WS ||
            phase == srlp_pkg::PH_MET_WS) begin
          runb = 1'b1;
        end else if (phase == srlp_pkg::PH_MET_DIG) begin
          ph = srlp_pkg::PH_DONE;
        end else begin
          ph = srlp_pkg::PH_ERR;
          fe = (phase == srlp_pkg::PH_TS_SIGN || phase == srlp_pkg::PH_TS_DIG) ?
               srlp_pkg::ST_SYNTAX : srlp_pkg::ST_RANGE;
        end
      end else begin
        runb = 1'b1;
      end
    end
    dig = c >= 8'h30 && c <= 8'h39;
    d = dig ? 4'(c - 8'h30) : 4'd0;
    ws = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    sgn = c == 8'h2b || c == 8'h2d;
    t10 = {time_accum[60:0], 3'b0} + {time_accum[62:0], 1'b0} + 64'(d);
    s10 = {sensor_accum, 3'b0} + {2'b0, sensor_accum, 1'b0} + 12'(d);
    m10 = {1'b0, metric_magnitude, 3'b0} + {3'b0, metric_magnitude, 1'b0} + 37'(d);
    mlim = neg[2] ? 33'h080000000 : 33'h07fffffff;
    if (runb && c == 8'h00) begin
      if (phase == srlp_pkg::PH_TS_WS || phase == srlp_pkg::PH_TS_SIGN ||
          phase == srlp_pkg::PH_TS_DIG) begin
        ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_SYNTAX;
      end else if (phase == srlp_pkg::PH_MET_DIG || phase == srlp_pkg::PH_MET_CR) begin
        ph = srlp_pkg::PH_DONE;
      end else begin
        ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE;
      end
    end else if (runb) begin
      case (phase)
        srlp_pkg::PH_TS_WS, srlp_pkg::PH_SEN_WS, srlp_pkg::PH_MET_WS: begin
          if (ws) begin
          end else if (sgn) begin
            if (phase == srlp_pkg::PH_TS_WS) begin
              ng[0] = neg[0] | c[2]; ph = srlp_pkg::PH_TS_SIGN;
            end else if (phase == srlp_pkg::PH_SEN_WS) begin
              ng[1] = neg[1] | c[2]; ph = srlp_pkg::PH_SEN_SIGN;
            end else begin
              ng[2] = neg[2] | c[2]; ph = srlp_pkg::PH_MET_SIGN;
            end
          end else if (!dig) begin
            ph = srlp_pkg::PH_ERR;
            fe = (phase == srlp_pkg::PH_TS_WS) ? srlp_pkg::ST_SYNTAX : srlp_pkg::ST_RANGE;
          end
        end
        srlp_pkg::PH_TS_SIGN, srlp_pkg::PH_SEN_SIGN, srlp_pkg::PH_MET_SIGN: begin
          if (!dig) begin
            ph = srlp_pkg::PH_ERR;
            fe = (phase == srlp_pkg::PH_TS_SIGN) ? srlp_pkg::ST_SYNTAX : srlp_pkg::ST_RANGE;
          end
        end
        srlp_pkg::PH_TS_DIG: begin
          if (!dig) begin
            if (c == 8'h20) ph = srlp_pkg::PH_SEN_WS;
            else begin ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_SYNTAX; end
          end
        end
        srlp_pkg::PH_SEN_DIG: begin
          if (!dig) begin
            if (c == 8'h20) ph = srlp_pkg::PH_MET_WS;
            else begin ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE; end
          end
        end
        srlp_pkg::PH_MET_DIG: begin
          if (!dig) begin
            if (c == 8'h20 || c == 8'h0a) ph = srlp_pkg::PH_DONE;
            else if (c == 8'h0d) ph = srlp_pkg::PH_MET_CR;
            else begin ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE; end
          end
        end
        default: begin
        end
      endcase
      if (dig) begin
        if (phase == srlp_pkg::PH_TS_WS || phase == srlp_pkg::PH_TS_SIGN ||
            phase == srlp_pkg::PH_TS_DIG) begin
          ph = srlp_pkg::PH_TS_DIG;
          if (time_accum > TLIM || (time_accum == TLIM && d > 4'd5)) begin
            ta = '1; ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_SYNTAX;
          end else ta = t10;
        end else if (phase == srlp_pkg::PH_SEN_WS || phase == srlp_pkg::PH_SEN_SIGN ||
                     phase == srlp_pkg::PH_SEN_DIG) begin
          ph = srlp_pkg::PH_SEN_DIG;
          if (s10 > 12'd255) begin
            sa = 9'd256; ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE;
          end else begin
            sa = s10[8:0];
            if (neg[1] && s10 != 12'd0) begin ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE; end
          end
        end else if (phase == srlp_pkg::PH_MET_WS || phase == srlp_pkg::PH_MET_SIGN ||
                     phase == srlp_pkg::PH_MET_DIG) begin
          ph = srlp_pkg::PH_MET_DIG;
          if (m10 > 37'(mlim)) begin
            ma = mlim + 33'd1; ph = srlp_pkg::PH_ERR; fe = srlp_pkg::ST_RANGE;
          end else ma = m10[32:0];
        end
      end
    end
  end

  // Line end closes the text exactly as a NUL would.
  always_comb begin
    srlp_pkg::phase_t pe;
    logic [1:0] fee;
    pe = ph; fee = fe;
    if (ph == srlp_pkg::PH_TS_WS || ph == srlp_pkg::PH_TS_SIGN || ph == srlp_pkg::PH_TS_DIG) begin
      pe = srlp_pkg::PH_ERR; fee = srlp_pkg::ST_SYNTAX;
    end else if (ph == srlp_pkg::PH_SEN_WS || ph == srlp_pkg::PH_SEN_SIGN ||
                 ph == srlp_pkg::PH_SEN_DIG || ph == srlp_pkg::PH_MET_WS ||
                 ph == srlp_pkg::PH_MET_SIGN) begin
      pe = srlp_pkg::PH_ERR; fee = srlp_pkg::ST_RANGE;
    end
    if (cnt_next == '0) status = srlp_pkg::ST_SYNTAX;
    else if (cnt_next > LIM) status = srlp_pkg::ST_TOOLONG;
    else if (pe == srlp_pkg::PH_ERR) status = fee;
    else status = srlp_pkg::ST_OK;
    phase_next = ph; time_next = ta; sensor_next = sa; metric_next = ma;
    neg_next = ng; ferr_next = fe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= srlp_pkg::PH_TS_WS;
      time_accum <= '0; sensor_accum <= '0; metric_magnitude <= '0;
      neg <= '0; pending_crlf <= 1'b0; first_error <= '0; byte_count <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= in_valid && line_end;
      if (in_valid && line_end) begin
        phase <= srlp_pkg::PH_TS_WS;
        time_accum <= '0; sensor_accum <= '0; metric_magnitude <= '0;
        neg <= '0; pending_crlf <= 1'b0; first_error <= '0; byte_count <= '0;
      end else begin
        phase <= phase_next; time_accum <= time_next; sensor_accum <= sensor_next;
        metric_magnitude <= metric_next; neg <= neg_next; pending_crlf <= pend_next;
        first_error <= ferr_next; byte_count <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && line_end) begin
      res.status <= status;
      if (status == srlp_pkg::ST_OK) begin
        res.timestamp <= neg_next[0] ? 64'(-time_next) : time_next;
        res.sensor <= sensor_next[7:0];
        res.metric <= neg_next[2] ? 32'(-metric_next) : metric_next[31:0];
      end else begin
        res.timestamp <= '0; res.sensor <= '0; res.metric <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && line_end) |-> phase == srlp_pkg::PH_TS_WS)
    else $error("parser state not cleared after line end");
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(in_valid && line_end))
    else $error("result without line end");
  assert property (@(posedge clk) disable iff (rst)
    phase == srlp_pkg::PH_ERR |-> first_error != srlp_pkg::ST_OK)
    else $error("error phase without error code");

endmodule

@@ hw/rtl/srlp_queue.sv @@
// Back part: a small result queue that decouples the parser from the consumer.
module srlp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  srlp_pkg::result_t wdata,
  input  logic              rd,
  output logic              empty,
  output logic              almost_full,
  output srlp_pkg::result_t rdata
);

  srlp_pkg::result_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign empty = cnt == 3'd0;
  assign almost_full = cnt >= 3'd3;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd && !empty) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst) wr |-> cnt != 3'd4)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (wr && !(rd && !empty)) |=> cnt == $past(cnt) + 3'd1)
    else $error("result queue count did not advance");

endmodule
